// ----- src/mouse_look_direction_top_defines.svh -----
// Assertion macros for the mouse look direction block.
// Each macro takes a label, a condition and a consequence, sampled on clk and
// switched off while arst_n is low.
`ifndef MOUSE_LOOK_DIRECTION_TOP_DEFINES_SVH
`define MOUSE_LOOK_DIRECTION_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MLD_ASSERT_SAME(label, ant, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
	else $error("mouse look direction: same-cycle check failed");

`define MLD_ASSERT_NEXT(label, ant, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
	else $error("mouse look direction: next-cycle check failed");

`else

`define MLD_ASSERT_SAME(label, ant, cons)

`define MLD_ASSERT_NEXT(label, ant, cons)

`endif

`endif

// ----- src/mld_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mld_pkg;

	localparam int ANGLE_FRAC_BITS = 8;
	localparam int DIR_FRAC_BITS   = 14;

	localparam int ANG_ONE     = 1 << ANGLE_FRAC_BITS;
	localparam int ANG_FULL    = 360 * ANG_ONE;
	localparam int ANG_HALF    = 180 * ANG_ONE;
	localparam int ANG_QUARTER = 90 * ANG_ONE;
	localparam int PITCH_LIMIT = 90 * ANG_ONE;
	localparam int PITCH_SNAP  = 89 * ANG_ONE;

	localparam int COORD_W     = 16;
	localparam int SENS_W      = 16;
	localparam int DELTA_W     = COORD_W + 1;
	localparam int PROD_W      = 2 * DELTA_W;
	localparam int SCALE_SHIFT = SENS_W - ANGLE_FRAC_BITS;
	localparam int STEP_W      = PROD_W - SCALE_SHIFT;
	localparam int PITCH_W     = ANGLE_FRAC_BITS + 8;
	localparam int PSUM_W      = STEP_W + 1;
	localparam int YAW_W       = ANGLE_FRAC_BITS + 9;
	localparam int YRED_W      = YAW_W + 2;

	// Yaw wrap: a bias of 256 turns keeps the sum positive, then nine
	// conditional subtractions of shifted turns bring it below one turn.
	localparam int WRAP_W      = ANGLE_FRAC_BITS + 18;
	localparam int WRAP_STEPS  = 9;
	localparam int WRAP_CNT_W  = $clog2(WRAP_STEPS);
	localparam int WRAP_BIAS   = 256 * ANG_FULL;

	localparam int SENS_RESET  = 3277;
	localparam int PREV_X_RESET = 400;
	localparam int PREV_Y_RESET = 300;
	localparam int YAW_RESET   = 270 * ANG_ONE;

	localparam int CORDIC_STEPS    = 20;
	localparam int CORDIC_ANG_BITS = 20;
	localparam int SHIFT_W         = $clog2(CORDIC_STEPS);
	localparam int Z_SHIFT         = CORDIC_ANG_BITS - ANGLE_FRAC_BITS;
	localparam int XY_W            = 32;
	localparam int Z_W             = 29;
	localparam int CORDIC_GAIN     = 652032874;

	localparam int DIR_W     = 16;
	localparam int MPROD_W   = 2 * XY_W;
	localparam int RND_W     = DIR_FRAC_BITS + 4;
	localparam int MUL_SHIFT = 2 * (XY_W - 2) - DIR_FRAC_BITS;
	localparam int SIN_SHIFT = (XY_W - 2) - DIR_FRAC_BITS;
	localparam int OUT_HI    = (1 << DIR_FRAC_BITS) > 32767 ? 32767 : (1 << DIR_FRAC_BITS);
	localparam int OUT_LO    = -(1 << DIR_FRAC_BITS) < -32768 ? -32768 :
		-(1 << DIR_FRAC_BITS);

	typedef struct packed {
		logic                   valid;
		logic                   neg;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cordic_t;

	// Arctangent of 2^-i in units of 2^-20 degree.
	function automatic logic signed [Z_W-1:0] atan_q20(input int i);
		logic signed [Z_W-1:0] r;
		case (i)
			0:  r = Z_W'(47185920);
			1:  r = Z_W'(27855475);
			2:  r = Z_W'(14718068);
			3:  r = Z_W'(7471121);
			4:  r = Z_W'(3750058);
			5:  r = Z_W'(1876857);
			6:  r = Z_W'(938658);
			7:  r = Z_W'(469357);
			8:  r = Z_W'(234682);
			9:  r = Z_W'(117342);
			10: r = Z_W'(58671);
			11: r = Z_W'(29335);
			12: r = Z_W'(14668);
			13: r = Z_W'(7334);
			14: r = Z_W'(3667);
			15: r = Z_W'(1833);
			16: r = Z_W'(917);
			17: r = Z_W'(458);
			18: r = Z_W'(229);
			19: r = Z_W'(115);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [STEP_W-1:0] step_round(
		input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + PROD_W'(1 << (SCALE_SHIFT - 1));
		return STEP_W'(t >>> SCALE_SHIFT);
	endfunction

	function automatic logic signed [RND_W-1:0] prod_round(
		input logic signed [MPROD_W-1:0] p);
		logic signed [MPROD_W-1:0] t;
		t = p + (MPROD_W'(1) <<< (MUL_SHIFT - 1));
		return RND_W'(t >>> MUL_SHIFT);
	endfunction

	function automatic logic signed [RND_W-1:0] sin_round(
		input logic signed [XY_W-1:0] s);
		logic signed [XY_W:0] t;
		t = (XY_W + 1)'(s) + (XY_W + 1)'(1 << (SIN_SHIFT - 1));
		return RND_W'(t >>> SIN_SHIFT);
	endfunction

	function automatic logic [DIR_W-1:0] sat_dir(input logic signed [RND_W-1:0] v);
		logic [DIR_W-1:0] r;
		if (v > OUT_HI) begin
			r = DIR_W'(OUT_HI);
		end else if (v < OUT_LO) begin
			r = DIR_W'(OUT_LO);
		end else begin
			r = DIR_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/mld_cordic_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mld_cordic_cell (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire mld_pkg::cordic_t                   cin,
	input  wire logic [mld_pkg::SHIFT_W-1:0]        shift,
	input  wire logic signed [mld_pkg::Z_W-1:0]     atan,
	output mld_pkg::cordic_t                        cout
);

	mld_pkg::cordic_t nxt;
	mld_pkg::cordic_t data_q;
	logic             valid_q;
	logic signed [mld_pkg::XY_W-1:0] xs;
	logic signed [mld_pkg::XY_W-1:0] ys;

	// One micro-rotation; the sign of the residual angle picks the direction.
	always_comb begin
		xs  = cin.x >>> shift;
		ys  = cin.y >>> shift;
		nxt = cin;
		if (cin.z >= 0) begin
			nxt.x = cin.x - ys;
			nxt.y = cin.y + xs;
			nxt.z = cin.z - atan;
		end else begin
			nxt.x = cin.x + ys;
			nxt.y = cin.y - xs;
			nxt.z = cin.z + atan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cin.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	always_comb begin
		cout       = data_q;
		cout.valid = valid_q;
	end

endmodule

`default_nettype wire

// ----- src/mld_cordic_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mld_cordic_chain (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mld_pkg::cordic_t cin,
	output mld_pkg::cordic_t      cout
);

	mld_pkg::cordic_t stage [0:mld_pkg::CORDIC_STEPS];

	assign stage[0] = cin;

	for (genvar i = 0; i < mld_pkg::CORDIC_STEPS; i++) begin : g_cell
		mld_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cin    (stage[i]),
			.shift  (mld_pkg::SHIFT_W'(i)),
			.atan   (mld_pkg::atan_q20(i)),
			.cout   (stage[i+1])
		);
	end

	assign cout = stage[mld_pkg::CORDIC_STEPS];

endmodule

`default_nettype wire

// ----- src/mouse_look_direction_top.sv -----
// Mouse-look camera direction. Each input item is a cursor position; the motion
// since the previous item, scaled by the sensitivity register, turns the yaw and
// pitch angles (yaw wraps at 360 degrees, pitch snaps to 89 degrees at the poles),
// and one item comes out with the unit view direction in signed Q1.14. The first
// item after reset only sets the reference position. A new item is taken only
// once the last one has been handed to the output register. Each item runs
// through the yaw wrap, then pitch and yaw walk one behind the other
// through a chain of 20 CORDIC cells, then one shared 32x32 multiplier forms the
// two cosine products. The result waits in an output register; the sequencer
// holds in its last step until that register is free. The sensitivity register
// may be written at any time but should change only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "mouse_look_direction_top_defines.svh"

module mouse_look_direction_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// cursor_x [15:0], cursor_y [31:16]
	input  wire logic [31:0] s_tdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// dir_x [15:0], dir_y [31:16], dir_z [47:32]
	output logic [47:0]      m_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// sensitivity [15:0]
	input  wire logic [15:0] cfg_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCALE_P,
		S_SCALE_Y,
		S_YAW_ADD,
		S_WRAP,
		S_FEED_P,
		S_FEED_Y,
		S_WAIT_P,
		S_WAIT_Y,
		S_MUL_X,
		S_MUL_Z,
		S_DONE
	} state_t;

	state_t state_q;

	logic [mld_pkg::SENS_W-1:0]                sens_q;
	logic signed [mld_pkg::COORD_W-1:0]        prev_x_q;
	logic signed [mld_pkg::COORD_W-1:0]        prev_y_q;
	logic                                      first_q;
	logic signed [mld_pkg::DELTA_W-1:0]        dx_q;
	logic signed [mld_pkg::DELTA_W-1:0]        dy_q;
	logic signed [mld_pkg::PROD_W-1:0]         prod_q;
	logic signed [mld_pkg::PITCH_W-1:0]        pitch_q;
	logic [mld_pkg::YAW_W-1:0]                 yaw_q;
	logic [mld_pkg::WRAP_W-1:0]                wrap_q;
	logic [mld_pkg::WRAP_CNT_W-1:0]            cnt_q;
	logic signed [mld_pkg::XY_W-1:0]           cp_q;
	logic signed [mld_pkg::XY_W-1:0]           sp_q;
	logic signed [mld_pkg::XY_W-1:0]           cy_q;
	logic signed [mld_pkg::XY_W-1:0]           sy_q;
	logic signed [mld_pkg::MPROD_W-1:0]        mprod_q;
	logic [mld_pkg::DIR_W-1:0]                 dir_x_q;
	logic                                      m_tvalid_q;
	logic [47:0]                               m_tdata_q;

	logic signed [mld_pkg::COORD_W-1:0]        cur_x;
	logic signed [mld_pkg::COORD_W-1:0]        cur_y;
	logic signed [mld_pkg::DELTA_W-1:0]        delta_x;
	logic signed [mld_pkg::DELTA_W-1:0]        delta_y;
	logic signed [mld_pkg::DELTA_W-1:0]        sens_ext;
	logic signed [mld_pkg::DELTA_W-1:0]        mul_in;
	logic signed [mld_pkg::PROD_W-1:0]         prod_next;
	logic signed [mld_pkg::STEP_W-1:0]         step;
	logic signed [mld_pkg::PSUM_W-1:0]         psum;
	logic signed [mld_pkg::PITCH_W-1:0]        pitch_next;
	logic [mld_pkg::WRAP_W-1:0]                wrap_start;
	logic [mld_pkg::WRAP_W-1:0]                wrap_sub;
	logic [mld_pkg::WRAP_W-1:0]                wrap_next;
	logic signed [mld_pkg::YRED_W-1:0]         ya0;
	logic signed [mld_pkg::YRED_W-1:0]         ya1;
	logic                                      yaw_neg;
	logic signed [mld_pkg::Z_W-1:0]            z_pitch;
	logic signed [mld_pkg::Z_W-1:0]            z_yaw;
	logic signed [mld_pkg::XY_W-1:0]           cos_out;
	logic signed [mld_pkg::XY_W-1:0]           sin_out;
	logic signed [mld_pkg::XY_W-1:0]           mul_b;
	logic signed [mld_pkg::MPROD_W-1:0]        mprod_next;
	logic                                      out_free;
	mld_pkg::cordic_t                          chain_in;
	mld_pkg::cordic_t                          chain_out;

	assign cur_x = s_tdata[15:0];
	assign cur_y = s_tdata[31:16];

	// The first item only loads the reference position.
	assign delta_x = first_q ? '0 :
		mld_pkg::DELTA_W'(cur_x) - mld_pkg::DELTA_W'(prev_x_q);
	assign delta_y = first_q ? '0 :
		mld_pkg::DELTA_W'(prev_y_q) - mld_pkg::DELTA_W'(cur_y);

	assign sens_ext  = $signed({1'b0, sens_q});
	assign mul_in    = (state_q == S_SCALE_P) ? dy_q : dx_q;
	assign prod_next = mld_pkg::PROD_W'(mul_in) * mld_pkg::PROD_W'(sens_ext);
	assign step      = mld_pkg::step_round(prod_q);

	always_comb begin
		psum = mld_pkg::PSUM_W'(pitch_q) + mld_pkg::PSUM_W'(step);
		if (psum >= mld_pkg::PITCH_LIMIT) begin
			pitch_next = mld_pkg::PITCH_W'(mld_pkg::PITCH_SNAP);
		end else if (psum <= -mld_pkg::PITCH_LIMIT) begin
			pitch_next = mld_pkg::PITCH_W'(-mld_pkg::PITCH_SNAP);
		end else begin
			pitch_next = psum[mld_pkg::PITCH_W-1:0];
		end
	end

	assign wrap_start = mld_pkg::WRAP_W'(yaw_q) + mld_pkg::WRAP_W'(step) +
		mld_pkg::WRAP_W'(mld_pkg::WRAP_BIAS);
	assign wrap_sub   = mld_pkg::WRAP_W'(mld_pkg::ANG_FULL) << cnt_q;
	assign wrap_next  = (wrap_q >= wrap_sub) ? wrap_q - wrap_sub : wrap_q;

	// Yaw is folded into [-90, 90] degrees; the far half flips the sign of
	// both results.
	always_comb begin
		ya0 = $signed({2'b00, yaw_q});
		if (ya0 >= mld_pkg::ANG_HALF) begin
			ya0 = ya0 - mld_pkg::YRED_W'(mld_pkg::ANG_FULL);
		end
		ya1     = ya0;
		yaw_neg = 1'b0;
		if (ya0 > mld_pkg::ANG_QUARTER) begin
			ya1     = ya0 - mld_pkg::YRED_W'(mld_pkg::ANG_HALF);
			yaw_neg = 1'b1;
		end else if (ya0 < -mld_pkg::ANG_QUARTER) begin
			ya1     = ya0 + mld_pkg::YRED_W'(mld_pkg::ANG_HALF);
			yaw_neg = 1'b1;
		end
	end

	assign z_pitch = mld_pkg::Z_W'(pitch_q) <<< mld_pkg::Z_SHIFT;
	assign z_yaw   = mld_pkg::Z_W'(ya1) <<< mld_pkg::Z_SHIFT;

	always_comb begin
		chain_in.valid = (state_q == S_FEED_P) || (state_q == S_FEED_Y);
		chain_in.neg   = (state_q == S_FEED_Y) && yaw_neg;
		chain_in.x     = mld_pkg::XY_W'(mld_pkg::CORDIC_GAIN);
		chain_in.y     = '0;
		chain_in.z     = (state_q == S_FEED_Y) ? z_yaw : z_pitch;
	end

	mld_cordic_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cin    (chain_in),
		.cout   (chain_out)
	);

	assign cos_out = chain_out.neg ? -chain_out.x : chain_out.x;
	assign sin_out = chain_out.neg ? -chain_out.y : chain_out.y;

	assign mul_b      = (state_q == S_MUL_X) ? cy_q : sy_q;
	assign mprod_next = mld_pkg::MPROD_W'(cp_q) * mld_pkg::MPROD_W'(mul_b);

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sens_q     <= mld_pkg::SENS_W'(mld_pkg::SENS_RESET);
			prev_x_q   <= mld_pkg::COORD_W'(mld_pkg::PREV_X_RESET);
			prev_y_q   <= mld_pkg::COORD_W'(mld_pkg::PREV_Y_RESET);
			first_q    <= 1'b1;
			dx_q       <= '0;
			dy_q       <= '0;
			prod_q     <= '0;
			pitch_q    <= '0;
			yaw_q      <= mld_pkg::YAW_W'(mld_pkg::YAW_RESET);
			wrap_q     <= '0;
			cnt_q      <= '0;
			cp_q       <= '0;
			sp_q       <= '0;
			cy_q       <= '0;
			sy_q       <= '0;
			mprod_q    <= '0;
			dir_x_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sens_q <= cfg_data;
			end
			// In the last step the output register is loaded below instead.
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						dx_q     <= delta_x;
						dy_q     <= delta_y;
						prev_x_q <= cur_x;
						prev_y_q <= cur_y;
						first_q  <= 1'b0;
						state_q  <= S_SCALE_P;
					end
				end
				S_SCALE_P: begin
					prod_q  <= prod_next;
					state_q <= S_SCALE_Y;
				end
				S_SCALE_Y: begin
					pitch_q <= pitch_next;
					prod_q  <= prod_next;
					state_q <= S_YAW_ADD;
				end
				S_YAW_ADD: begin
					wrap_q  <= wrap_start;
					cnt_q   <= mld_pkg::WRAP_CNT_W'(mld_pkg::WRAP_STEPS - 1);
					state_q <= S_WRAP;
				end
				S_WRAP: begin
					wrap_q <= wrap_next;
					if (cnt_q == '0) begin
						yaw_q   <= wrap_next[mld_pkg::YAW_W-1:0];
						state_q <= S_FEED_P;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_FEED_P: begin
					state_q <= S_FEED_Y;
				end
				S_FEED_Y: begin
					state_q <= S_WAIT_P;
				end
				S_WAIT_P: begin
					if (chain_out.valid) begin
						cp_q    <= cos_out;
						sp_q    <= sin_out;
						state_q <= S_WAIT_Y;
					end
				end
				S_WAIT_Y: begin
					cy_q    <= cos_out;
					sy_q    <= sin_out;
					state_q <= S_MUL_X;
				end
				S_MUL_X: begin
					mprod_q <= mprod_next;
					state_q <= S_MUL_Z;
				end
				S_MUL_Z: begin
					dir_x_q <= mld_pkg::sat_dir(mld_pkg::prod_round(mprod_q));
					mprod_q <= mprod_next;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_tdata_q <= {mld_pkg::sat_dir(mld_pkg::prod_round(mprod_q)),
							mld_pkg::sat_dir(mld_pkg::sin_round(sp_q)), dir_x_q};
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The stored angles always sit inside their legal ranges.
	`MLD_ASSERT_SAME(a_pitch_clamped, 1'b1, pitch_q < mld_pkg::PITCH_LIMIT && pitch_q > -mld_pkg::PITCH_LIMIT)
	`MLD_ASSERT_SAME(a_yaw_wrapped, 1'b1, yaw_q < mld_pkg::ANG_FULL)
	// Rotated vectors leave the chain only while the sequencer waits for them.
	`MLD_ASSERT_SAME(a_chain_expected, chain_out.valid, state_q == S_WAIT_P || state_q == S_WAIT_Y)
	`MLD_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_q == S_SCALE_P && !first_q)

endmodule

`default_nettype wire
